// ----- design/psp_pkg.sv -----
`timescale 1ns / 1ps
package psp_pkg;

  localparam int SUPPLY_BITS = 21;
  localparam logic [SUPPLY_BITS-1:0] VCC_NUMERATOR = 21'd1125300;
  localparam int FS_SHIFT = 10;
  localparam int FULL_SCALE = 1023;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS = 16;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_THROTTLE_SLOPE,
    CFG_THROTTLE_OFFSET,
    CFG_BRAKE_DRIVE_THRESHOLD,
    CFG_BRAKE_MARGIN,
    CFG_PEDAL_MISMATCH_LIMIT,
    CFG_PEDAL_QUARTER_THRESHOLD,
    CFG_PEDAL_RATIO_NUM,
    CFG_PEDAL_RATIO_DEN
  } cfg_reg_t;

  localparam logic signed [11:0] RST_THROTTLE_SLOPE = 12'sd1;
  localparam logic signed [15:0] RST_THROTTLE_OFFSET = 16'sd0;
  localparam logic [15:0] RST_BRAKE_DRIVE_THRESHOLD = 16'd750;
  localparam logic [15:0] RST_BRAKE_MARGIN = 16'd500;
  localparam logic [15:0] RST_PEDAL_MISMATCH_LIMIT = 16'd500;
  localparam logic [15:0] RST_PEDAL_QUARTER_THRESHOLD = 16'd1250;
  localparam logic [7:0] RST_PEDAL_RATIO_NUM = 8'd1;
  localparam logic [7:0] RST_PEDAL_RATIO_DEN = 8'd1;

endpackage

// ----- design/psp_in_if.sv -----
`timescale 1ns / 1ps
interface psp_in_if #(
  parameter int COUNT_BITS = 10
) ();
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] reference_count;
  logic [COUNT_BITS-1:0] brake_count;
  logic [COUNT_BITS-1:0] pedal_one_count;
  logic [COUNT_BITS-1:0] pedal_two_count;
  logic [COUNT_BITS-1:0] throttle_one_count;
  logic [COUNT_BITS-1:0] throttle_two_count;
  logic                  hv_request;
  logic                  drive_button;
  logic                  charge_detect;
  logic [4:0]            fault_lines;
  logic                  prior_pedal_fault;

  modport source (
    output valid, reference_count, brake_count, pedal_one_count, pedal_two_count,
           throttle_one_count, throttle_two_count, hv_request, drive_button,
           charge_detect, fault_lines, prior_pedal_fault,
    input  ready
  );
  modport sink (
    input  valid, reference_count, brake_count, pedal_one_count, pedal_two_count,
           throttle_one_count, throttle_two_count, hv_request, drive_button,
           charge_detect, fault_lines, prior_pedal_fault,
    output ready
  );
endinterface

// ----- design/psp_out_if.sv -----
`timescale 1ns / 1ps
interface psp_out_if ();
  logic valid;
  logic ready;
  logic neutral_req;
  logic drive_req;
  logic charger_on;
  logic charger_off;
  logic pedal_fault;
  logic pedal_fault_clear;
  logic hard_fault;

  modport source (
    output valid, neutral_req, drive_req, charger_on, charger_off, pedal_fault,
           pedal_fault_clear, hard_fault,
    input  ready
  );
  modport sink (
    input  valid, neutral_req, drive_req, charger_on, charger_off, pedal_fault,
           pedal_fault_clear, hard_fault,
    output ready
  );
endinterface

// ----- design/psp_cfg_if.sv -----
`timescale 1ns / 1ps
interface psp_cfg_if
  import psp_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- design/psp_recip_div.sv -----
`timescale 1ns / 1ps
module psp_recip_div
  import psp_pkg::*;
#(
  parameter int DEN_W = 10,
  parameter int SIDE_W = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [DEN_W-1:0]       den,
  input  logic [SIDE_W-1:0]      side_in,
  output logic                   out_valid,
  output logic [SUPPLY_BITS-1:0] quot,
  output logic [SIDE_W-1:0]      side_out
);
  localparam int N = SUPPLY_BITS;

  logic              vld      [N];
  logic [DEN_W-1:0]  rem      [N];
  logic [DEN_W-1:0]  dv       [N];
  logic [N-1:0]      q        [N];
  logic [SIDE_W-1:0] sd       [N];
  logic              vld_next [N];
  logic [DEN_W-1:0]  rem_next [N];
  logic [DEN_W-1:0]  dv_next  [N];
  logic [N-1:0]      q_next   [N];
  logic [SIDE_W-1:0] sd_next  [N];

  // restoring division of the fixed dividend, one quotient bit per stage
  always_comb begin
    logic [DEN_W-1:0] prem;
    logic [DEN_W-1:0] pden;
    logic [N-1:0]     pq;
    logic [DEN_W:0]   trial;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        vld_next[k] = in_valid;
        prem = '0;
        pden = den;
        pq = '0;
        sd_next[k] = side_in;
      end else begin
        vld_next[k] = vld[k-1];
        prem = rem[k-1];
        pden = dv[k-1];
        pq = q[k-1];
        sd_next[k] = sd[k-1];
      end
      trial = {prem, VCC_NUMERATOR[N-1-k]};
      dv_next[k] = pden;
      if (trial >= {1'b0, pden}) begin
        rem_next[k] = trial[DEN_W-1:0] - pden;
        q_next[k] = {pq[N-2:0], 1'b1};
      end else begin
        rem_next[k] = trial[DEN_W-1:0];
        q_next[k] = {pq[N-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < N; k++) vld[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < N; k++) vld[k] <= vld_next[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        rem[k] <= rem_next[k];
        dv[k] <= dv_next[k];
        q[k] <= q_next[k];
        sd[k] <= sd_next[k];
      end
    end
  end

  assign out_valid = vld[N-1];
  assign quot = q[N-1];
  assign side_out = sd[N-1];
endmodule

// ----- design/pedal_sensor_plausibility.sv -----
`timescale 1ns / 1ps
// Accelerator pedal plausibility check.
// snapshot: one transfer per sample of converter counts and switch lines.
// events:   one transfer of seven flags per snapshot, in order.
// cfg:      register writes (index, data), always ready; write only while
//           no snapshot is in flight.
// Supply mV = 1125300 / reference count (count 0 reads as 1), then each
// count is scaled by supply / 1023 and checked against the pedal, brake
// and throttle limits.
// Pipeline: 21-stage quotient pipeline for the supply, then five stages of
// scaling, products and compares, from snapshot transfer to events valid.
// Throughput: one snapshot per cycle while events is not stalled.
// Stall: the whole pipeline holds while events is valid and not ready;
// snapshot.ready follows that same enable, so nothing is dropped.
// Reset (synchronous): pipeline empties, registers return to defaults.
module pedal_sensor_plausibility
  import psp_pkg::*;
#(
  parameter int COUNT_BITS = 10
) (
  input  logic      clk,
  input  logic      rst,
  psp_cfg_if.sink   cfg,
  psp_in_if.sink    snapshot,
  psp_out_if.source events
);
  localparam int CW = COUNT_BITS;
  localparam int PROD_W = SUPPLY_BITS + CW;
  localparam int MV_W = PROD_W - 9;
  localparam int SUM_W = PROD_W + 1;
  localparam int UW = (MV_W > 16) ? MV_W : 16;
  localparam int DW = UW + 2;
  localparam int CMP_W = DW + 9;
  localparam int BW = MV_W + 13;
  localparam int BND_W = BW + 1;
  localparam int SIDE_W = 5 * CW + 5;

  logic signed [11:0] throttle_slope;
  logic signed [15:0] throttle_offset;
  logic [15:0] brake_drive_threshold;
  logic [15:0] brake_margin;
  logic [15:0] pedal_mismatch_limit;
  logic [15:0] pedal_quarter_threshold;
  logic [7:0]  pedal_ratio_num;
  logic [7:0]  pedal_ratio_den;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      throttle_slope <= RST_THROTTLE_SLOPE;
      throttle_offset <= RST_THROTTLE_OFFSET;
      brake_drive_threshold <= RST_BRAKE_DRIVE_THRESHOLD;
      brake_margin <= RST_BRAKE_MARGIN;
      pedal_mismatch_limit <= RST_PEDAL_MISMATCH_LIMIT;
      pedal_quarter_threshold <= RST_PEDAL_QUARTER_THRESHOLD;
      pedal_ratio_num <= RST_PEDAL_RATIO_NUM;
      pedal_ratio_den <= RST_PEDAL_RATIO_DEN;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        CFG_THROTTLE_SLOPE:          throttle_slope <= cfg.data[11:0];
        CFG_THROTTLE_OFFSET:         throttle_offset <= cfg.data;
        CFG_BRAKE_DRIVE_THRESHOLD:   brake_drive_threshold <= cfg.data;
        CFG_BRAKE_MARGIN:            brake_margin <= cfg.data;
        CFG_PEDAL_MISMATCH_LIMIT:    pedal_mismatch_limit <= cfg.data;
        CFG_PEDAL_QUARTER_THRESHOLD: pedal_quarter_threshold <= cfg.data;
        CFG_PEDAL_RATIO_NUM:         pedal_ratio_num <= cfg.data[7:0];
        CFG_PEDAL_RATIO_DEN:         pedal_ratio_den <= cfg.data[7:0];
      endcase
    end
  end

  logic en;
  logic out_valid;

  assign en = !out_valid || events.ready;
  assign snapshot.ready = en;

  // supply divider, counts and flags ride along
  logic [CW-1:0]          div_den;
  logic [SIDE_W-1:0]      side_in;
  logic                   d_valid;
  logic [SUPPLY_BITS-1:0] d_supply;
  logic [SIDE_W-1:0]      d_side;

  assign div_den = (snapshot.reference_count == '0) ? CW'(1) : snapshot.reference_count;
  assign side_in = {snapshot.hv_request, snapshot.drive_button, snapshot.charge_detect,
                    snapshot.prior_pedal_fault, (snapshot.fault_lines == '0),
                    snapshot.throttle_two_count, snapshot.throttle_one_count,
                    snapshot.pedal_two_count, snapshot.pedal_one_count,
                    snapshot.brake_count};

  psp_recip_div #(
    .DEN_W (CW),
    .SIDE_W(SIDE_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (snapshot.valid),
    .den      (div_den),
    .side_in  (side_in),
    .out_valid(d_valid),
    .quot     (d_supply),
    .side_out (d_side)
  );

  // channel order: brake, pedal one, pedal two, throttle one, throttle two
  logic              s1_valid, s2_valid, s3_valid, s4_valid;
  logic [4:0]        s1_flags, s2_flags, s3_flags, s4_flags;
  logic [PROD_W-1:0] s1_prod [5];
  logic [PROD_W-1:0] s2_x    [5];
  logic [MV_W-1:0]   s2_q    [5];
  logic [MV_W-1:0]   s3_mv   [5];
  logic [MV_W-1:0]   q_est   [5];
  logic [MV_W-1:0]   mv_fix  [5];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= d_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  // x / 1023 estimate from x * (2^-10 + 2^-20 + 2^-30 + 2^-40): low by at most one
  always_comb begin
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] r;
    for (int i = 0; i < 5; i++) begin
      sum = SUM_W'(s1_prod[i]) + SUM_W'(s1_prod[i] >> FS_SHIFT)
          + SUM_W'(s1_prod[i] >> (2 * FS_SHIFT)) + SUM_W'(s1_prod[i] >> (3 * FS_SHIFT));
      q_est[i] = MV_W'(sum >> FS_SHIFT);
      r = SUM_W'(s2_x[i]) - (SUM_W'(s2_q[i]) << FS_SHIFT) + SUM_W'(s2_q[i]);
      mv_fix[i] = (r >= SUM_W'(FULL_SCALE)) ? s2_q[i] + MV_W'(1) : s2_q[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_flags <= d_side[5*CW +: 5];
      s2_flags <= s1_flags;
      s3_flags <= s2_flags;
      for (int i = 0; i < 5; i++) begin
        s1_prod[i] <= PROD_W'(d_supply) * PROD_W'(d_side[i*CW +: CW]);
        s2_x[i] <= s1_prod[i];
        s2_q[i] <= q_est[i];
        s3_mv[i] <= mv_fix[i];
      end
    end
  end

  // stage 4: products for mismatch and throttle bounds, threshold compares
  logic signed [DW-1:0]    p1_d, lo_d, hi_d;
  logic signed [8:0]       den_s;
  logic signed [CMP_W-1:0] s4_p, s4_a, s4_b;
  logic signed [BW-1:0]    s4_b1, s4_b2;
  logic [MV_W-1:0]         s4_p1;
  logic                    s4_drive_hi, s4_brake_m, s4_p1_q;

  assign p1_d = DW'(signed'({1'b0, s3_mv[1]}));
  assign lo_d = p1_d - DW'(signed'({1'b0, pedal_mismatch_limit}));
  assign hi_d = p1_d + DW'(signed'({1'b0, pedal_mismatch_limit})) + DW'(1);
  assign den_s = signed'({1'b0, (pedal_ratio_den == '0) ? 8'd1 : pedal_ratio_den});

  always_ff @(posedge clk) begin
    if (en) begin
      s4_flags <= s3_flags;
      s4_p1 <= s3_mv[1];
      s4_p <= CMP_W'(signed'({1'b0, s3_mv[2]})) * CMP_W'(signed'({1'b0, pedal_ratio_num}));
      s4_a <= CMP_W'(lo_d) * CMP_W'(den_s);
      s4_b <= CMP_W'(hi_d) * CMP_W'(den_s);
      s4_b1 <= BW'(throttle_slope) * BW'(signed'({1'b0, s3_mv[3]}));
      s4_b2 <= BW'(throttle_slope) * BW'(signed'({1'b0, s3_mv[4]}));
      s4_drive_hi <= UW'(s3_mv[0]) > UW'(brake_drive_threshold);
      s4_brake_m <= UW'(s3_mv[0]) > UW'(brake_margin);
      s4_p1_q <= UW'(s3_mv[1]) > UW'(pedal_quarter_threshold);
    end
  end

  // stage 5: bounds and fault decision into the output register
  logic signed [BND_W-1:0] bnd1, bnd2, p1_b;
  logic                    implausible;

  assign bnd1 = BND_W'(s4_b1) + BND_W'(throttle_offset);
  assign bnd2 = BND_W'(s4_b2) + BND_W'(throttle_offset);
  assign p1_b = BND_W'(signed'({1'b0, s4_p1}));
  // p1-floor(p2*num/den) past +-limit (no divide), brake+pedal, or p1 off bnd1/2
  assign implausible = (s4_p < s4_a) || (s4_p >= s4_b) || (s4_brake_m && s4_p1_q)
                    || (p1_b < bnd1) || (p1_b > bnd2);

  logic neutral_req, drive_req, charger_on, pedal_fault, pedal_fault_clear, hard_fault;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s4_valid;
    end
  end

  // flags: {hv, drive, charge, prior, hard}
  always_ff @(posedge clk) begin
    if (en) begin
      neutral_req <= s4_flags[4];
      drive_req <= s4_flags[3] || s4_drive_hi;
      charger_on <= s4_flags[2];
      pedal_fault <= implausible;
      pedal_fault_clear <= !s4_flags[1] && !implausible;
      hard_fault <= s4_flags[0];
    end
  end

  assign events.valid = out_valid;
  assign events.neutral_req = neutral_req;
  assign events.drive_req = drive_req;
  assign events.charger_on = charger_on;
  assign events.charger_off = !charger_on;
  assign events.pedal_fault = pedal_fault;
  assign events.pedal_fault_clear = pedal_fault_clear;
  assign events.hard_fault = hard_fault;
endmodule

// ----- design/psp_checker.sv -----
`timescale 1ns / 1ps
module psp_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] flags
);
  // flags: neutral, drive, charger on, charger off, pedal fault, fault clear, hard

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("events valid dropped during stall");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(flags))
    else $error("events payload changed during stall");

  a_stall_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("snapshot taken while events stalled");

  a_charge_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> flags[4] != flags[3])
    else $error("charger on and charger off agree");

  a_cleared_vs_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && flags[1] |-> !flags[2])
    else $error("pedal fault reported as cleared");

endmodule

bind pedal_sensor_plausibility psp_checker u_psp_checker (
  .clk      (clk),
  .rst      (rst),
  .in_ready (snapshot.ready),
  .out_valid(events.valid),
  .out_ready(events.ready),
  .flags    ({events.neutral_req, events.drive_req, events.charger_on, events.charger_off,
              events.pedal_fault, events.pedal_fault_clear, events.hard_fault})
);
